// ===== src/lfra_pkg.sv =====
// Shared types and constants for the lowest-free resource allocator.
package lfra_pkg;

   localparam int CSR_W    = 5;
   localparam int TIME_IN_W = 32;
   localparam int ID_W     = 16;
   localparam int PROC_W   = 4;
   localparam int PICK_W   = 6;

   localparam logic [CSR_W-1:0] ACTIVE_RESET = 5'd16;

   // Grant chain carried from one cell to the next.
   typedef struct packed {
      logic              taken;
      logic [PICK_W-1:0] pick;
   } lfra_link_type;

   // Per-beat control broadcast to every cell.
   typedef struct packed {
      logic fire;
      logic clear;
      logic enable;
   } lfra_cell_ctl_type;

endpackage

// ===== src/lfra_cell.sv =====
// One processor slot: busy-until register, free test and grant chain stage.
module lfra_cell #(
   parameter int INDEX  = 0,
   parameter int TIME_W = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lfra_pkg::lfra_cell_ctl_type    ctl,
   input  logic [lfra_pkg::CSR_W-1:0]     active,
   input  logic [TIME_W-1:0]              start,
   input  logic [TIME_W-1:0]              duration,
   input  lfra_pkg::lfra_link_type        link_in,
   output lfra_pkg::lfra_link_type        link_out
);
   import lfra_pkg::*;

   logic [TIME_W:0] busy_ff;
   logic [TIME_W:0] busy_in;
   logic [TIME_W:0] busy_eff;
   logic            eligible;
   logic            free;
   logic            take;

   always_comb begin
      busy_eff = ctl.clear ? '0 : busy_ff;
      eligible = 32'(INDEX) < 32'(active);
      free     = eligible && (busy_eff <= {1'b0, start});
      take     = ctl.enable && free && !link_in.taken;

      link_out.taken = link_in.taken | free;
      link_out.pick  = (!link_in.taken && free) ? PICK_W'(INDEX) : link_in.pick;

      busy_in = busy_ff;
      if (ctl.fire) begin
         busy_in = take ? ({1'b0, start} + {1'b0, duration}) : busy_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== src/lowest_free_resource_allocator.sv =====
// Top level of the lowest-free resource allocator: cell row, failure flag, result register.
//
// Usage: tasks arrive on the req_ channel already sorted by start time. Each
// beat carries start time, duration, task id and a first-of-batch mark. One
// rsp_ beat comes back per task with the echoed id, the processor granted and
// an assigned bit (0 when no active processor was free, or when the batch
// already failed; the failure holds until the next first-of-batch beat).
// The csr_ port writes active_procs, the count of processors in play; write
// it only while no task is outstanding. Values above MAX_PROCS act as
// MAX_PROCS, zero makes every task fail.
// Result: registered, in the rsp_ output register in the cycle after accept.
// Throughput: one task per cycle while req_stall is low. Each cell compares in parallel;
// the grant ripples once through the row of MAX_PROCS cells, which sets the cycle time.
// Stall: req_stall rises only while a result sits in the output register and
// rsp_stall holds it; a result taken in the same cycle frees the slot.
// Reset: all busy-until times and the failure flag clear, active_procs goes to
// 16, no result is pending.
module lowest_free_resource_allocator #(
   parameter int MAX_PROCS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lfra_pkg::TIME_IN_W-1:0] req_start_time,
   input  logic [lfra_pkg::TIME_IN_W-1:0] req_duration,
   input  logic [lfra_pkg::ID_W-1:0]      req_task_id,
   input  logic                           req_first_of_batch,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lfra_pkg::ID_W-1:0]      rsp_task_id_out,
   output logic [lfra_pkg::PROC_W-1:0]    rsp_processor,
   output logic                           rsp_assigned,
   input  logic                           csr_wr_en,
   input  logic [lfra_pkg::CSR_W-1:0]     csr_wr_data
);
   import lfra_pkg::*;

   logic [CSR_W-1:0]               active_ff;
   logic                           failed_ff;
   logic                           failed_in;
   logic                           failed_eff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [ID_W-1:0]                rsp_id_ff;
   logic [PROC_W-1:0]              rsp_proc_ff;
   logic [PROC_W-1:0]              rsp_proc_in;
   logic                           rsp_assigned_ff;
   logic                           rsp_assigned_in;
   logic                           accept;
   logic [TIME_BITS+TIME_IN_W-1:0] start_wide;
   logic [TIME_BITS+TIME_IN_W-1:0] dur_wide;
   logic [TIME_BITS-1:0]           start;
   logic [TIME_BITS-1:0]           duration;
   lfra_cell_ctl_type              ctl;
   lfra_link_type                  link [MAX_PROCS+1];

   // Accept whenever the output slot is empty or drains this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Keep the low TIME_BITS bits of each time field, zero-extend if wider.
   assign start_wide = {{TIME_BITS{1'b0}}, req_start_time};
   assign dur_wide   = {{TIME_BITS{1'b0}}, req_duration};
   assign start      = start_wide[TIME_BITS-1:0];
   assign duration   = dur_wide[TIME_BITS-1:0];

   // A batch start drops the earlier failure before this task is judged.
   assign failed_eff = req_first_of_batch ? 1'b0 : failed_ff;

   assign ctl.fire   = accept;
   assign ctl.clear  = req_first_of_batch;
   assign ctl.enable = ~failed_eff;

   // Head of the grant chain: nothing taken yet.
   assign link[0].taken = 1'b0;
   assign link[0].pick  = '0;

   for (genvar p = 0; p < MAX_PROCS; p++) begin : g_cell
      lfra_cell #(
         .INDEX  (p),
         .TIME_W (TIME_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .active   (active_ff),
         .start    (start),
         .duration (duration),
         .link_in  (link[p]),
         .link_out (link[p+1])
      );
   end

   always_comb begin
      rsp_assigned_in = ~failed_eff & link[MAX_PROCS].taken;
      // Processor number is masked to the field width; zero when not granted.
      rsp_proc_in     = rsp_assigned_in ? link[MAX_PROCS].pick[PROC_W-1:0] : '0;
      failed_in       = failed_eff | ~link[MAX_PROCS].taken;
      rsp_valid_in    = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         if (accept) begin
            failed_ff <= failed_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_id_ff       <= req_task_id;
         rsp_proc_ff     <= rsp_proc_in;
         rsp_assigned_ff <= rsp_assigned_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_id_out = rsp_id_ff;
   assign rsp_processor   = rsp_proc_ff;
   assign rsp_assigned    = rsp_assigned_ff;

endmodule
